/* rtl/core/seval_pkg.sv */
package seval_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int WORD_W      = 32;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int DIV_CNT_W   = $clog2(WORD_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_NUM = 3'd0,
      CMD_ADD = 3'd1,
      CMD_SUB = 3'd2,
      CMD_MUL = 3'd3,
      CMD_DIV = 3'd4,
      CMD_REM = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_SYNTAX   = 2'd1,
      STS_DIVZERO  = 2'd2,
      STS_OVERFLOW = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // token accepted this edge
      logic exec;       // apply the held token
      logic div_start;  // launch the divider
      logic div_wb;     // write quotient/remainder back
      logic finish;     // load result register, clear expression
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic tok_last;
      logic rsp_free;
   } dp_sts_type;

endpackage

/* rtl/core/seval_ram.sv */
module seval_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/seval_div.sv */
module seval_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [seval_pkg::WORD_W-1:0] dividend,
   input  logic [seval_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [seval_pkg::WORD_W-1:0] quotient,
   output logic [seval_pkg::WORD_W-1:0] remainder
);

   import seval_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [WORD_W-1:0]    dvs_ff, dvs_in;
   logic [WORD_W:0]      partial;
   logic [WORD_W:0]      diff;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      partial = {rem_ff, quo_ff[WORD_W-1]};
      diff    = partial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (diff[WORD_W]) begin
            rem_in = partial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end else begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/core/seval_datapath.sv */
module seval_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  seval_pkg::ctrl_cmd_type         cmd,
   output seval_pkg::dp_sts_type           sts,
   input  logic [seval_pkg::CMD_W-1:0]     req_cmd,
   input  logic signed [seval_pkg::WORD_W-1:0] req_operand,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [seval_pkg::WORD_W-1:0] rsp_value,
   output logic [seval_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                            csr_we,
   input  logic                            csr_wdata
);

   import seval_pkg::*;

   // held token
   logic [CMD_W-1:0]   tok_cmd_ff;
   logic [WORD_W-1:0]  tok_operand_ff;
   logic               tok_last_ff;

   // stack: top kept in a register, entries below it in the RAM
   logic [WORD_W-1:0]  tos_ff, tos_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   status_type         err_ff, err_in;
   logic               prefix_order_ff;

   logic               neg_q_ff, neg_r_ff, is_rem_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic [WORD_W-1:0]  next_opnd;
   logic [WORD_W-1:0]  lhs, rhs, lhs_mag, rhs_mag;
   logic [WORD_W-1:0]  alu_res, div_res;
   logic [LEVEL_W-1:0] level_dec, level_sub2;
   logic               err_none, is_num, is_op, is_divop, few_opnds, rhs_zero;
   logic               ram_we;
   logic               div_done;
   logic [WORD_W-1:0]  div_quo, div_rem;

   assign level_dec  = level_ff - LEVEL_W'(1);
   assign level_sub2 = level_ff - LEVEL_W'(2);

   seval_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (level_dec[ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_addr (level_sub2[ADDR_W-1:0]),
      .rd_data (next_opnd)
   );

   // operand roles follow the order mode
   assign lhs = prefix_order_ff ? tos_ff : next_opnd;
   assign rhs = prefix_order_ff ? next_opnd : tos_ff;
   assign lhs_mag = lhs[WORD_W-1] ? (WORD_W'(0) - lhs) : lhs;
   assign rhs_mag = rhs[WORD_W-1] ? (WORD_W'(0) - rhs) : rhs;

   seval_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (lhs_mag),
      .divisor   (rhs_mag),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign err_none  = (err_ff == STS_OK);
   assign is_num    = (tok_cmd_ff == CMD_NUM);
   assign is_op     = (tok_cmd_ff >= CMD_ADD) && (tok_cmd_ff <= CMD_REM);
   assign is_divop  = (tok_cmd_ff == CMD_DIV) || (tok_cmd_ff == CMD_REM);
   assign few_opnds = (level_ff < LEVEL_W'(2));
   assign rhs_zero  = (rhs == '0);

   always_comb begin
      case (tok_cmd_ff)
         CMD_ADD: alu_res = lhs + rhs;
         CMD_SUB: alu_res = lhs - rhs;
         CMD_MUL: alu_res = lhs * rhs;
         default: alu_res = '0;
      endcase
   end

   // truncating signed result; quotient takes xor of signs, remainder the dividend's
   always_comb begin
      if (is_rem_ff) begin
         div_res = neg_r_ff ? (WORD_W'(0) - div_rem) : div_rem;
      end else begin
         div_res = neg_q_ff ? (WORD_W'(0) - div_quo) : div_quo;
      end
   end

   always_comb begin
      tos_in        = tos_ff;
      level_in      = level_ff;
      err_in        = err_ff;
      ram_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.exec && err_none) begin
         if (is_num) begin
            if (level_ff == LEVEL_W'(STACK_DEPTH)) begin
               err_in = STS_OVERFLOW;
            end else begin
               ram_we   = (level_ff != '0);
               tos_in   = tok_operand_ff;
               level_in = level_ff + LEVEL_W'(1);
            end
         end else if (!is_op || few_opnds) begin
            err_in = STS_SYNTAX;
         end else if (is_divop && rhs_zero) begin
            err_in = STS_DIVZERO;
         end else if (!is_divop) begin
            tos_in   = alu_res;
            level_in = level_dec;
         end
      end

      if (cmd.div_wb) begin
         tos_in   = div_res;
         level_in = level_dec;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (!err_none) begin
            rsp_value_in  = '0;
            rsp_status_in = err_ff;
         end else if (level_ff == '0) begin
            rsp_value_in  = '0;
            rsp_status_in = STS_SYNTAX;
         end else begin
            rsp_value_in  = tos_ff;
            rsp_status_in = STS_OK;
         end
         level_in = '0;
         err_in   = STS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= '0;
         err_ff          <= STS_OK;
         prefix_order_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         level_ff     <= level_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            prefix_order_ff <= csr_wdata;
         end
      end
      if (cmd.capture) begin
         tok_cmd_ff     <= req_cmd;
         tok_operand_ff <= req_operand;
         tok_last_ff    <= req_last;
      end
      if (cmd.div_start) begin
         neg_q_ff  <= lhs[WORD_W-1] ^ rhs[WORD_W-1];
         neg_r_ff  <= lhs[WORD_W-1];
         is_rem_ff <= (tok_cmd_ff == CMD_REM);
      end
      tos_ff        <= tos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign sts.need_div = err_none && is_divop && !few_opnds && !rhs_zero;
   assign sts.div_done = div_done;
   assign sts.tok_last = tok_last_ff;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (level_ff == '0) && (err_ff == STS_OK) && rsp_valid_ff)
      else $error("expression not cleared after result");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STS_OK) |-> (rsp_value_ff == '0))
      else $error("error result carries a nonzero value");

   a_wb_after_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_wb |-> div_done)
      else $error("divider result written before done");
`endif

endmodule

/* rtl/core/seval_ctrl.sv */
module seval_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  seval_pkg::dp_sts_type   sts,
   output seval_pkg::ctrl_cmd_type cmd
);

   import seval_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (sts.div_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!sts.tok_last || sts.rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.exec      = (state_ff == S_FETCH);
      cmd.div_start = (state_ff == S_FETCH) && sts.need_div;
      cmd.div_wb    = (state_ff == S_DIV) && sts.div_done;
      cmd.finish    = (state_ff == S_DONE) && sts.tok_last && sts.rsp_free;
   end

endmodule

/* rtl/core/stack_expression_evaluator_unit.sv */
// Tokens are taken one at a time: number, add, subtract, multiply and error tokens pass through
// FETCH and DONE; divide and remainder tokens also wait in DIV on the bit-per-cycle 32-bit divider.
// A last token's result enters the output register in its final cycle and holds there
// until taken; a further last token stalls in its final cycle until that register frees.
// Reset (synchronous, active high) empties the stack, clears the error and selects postfix
// order; stack contents are not cleared and need no sweep.
module stack_expression_evaluator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // token input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [seval_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [seval_pkg::WORD_W-1:0] req_operand,
   input  logic                                req_last,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [seval_pkg::WORD_W-1:0] rsp_value,
   output logic [seval_pkg::STATUS_W-1:0]      rsp_status,
   // order mode register
   input  logic                                csr_we,
   input  logic                                csr_wdata
);

   import seval_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // Controller: one token at a time, IDLE -> FETCH -> (DIV) -> DONE.
   // FETCH has the operand below the top out of the stack RAM (read issued at accept).
   seval_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: top-of-stack register, stack RAM, ALU, divider, error
   // tracking and the result register.
   seval_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_cmd     (req_cmd),
      .req_operand (req_operand),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

endmodule
